### rtl/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
`default_nettype none
package rau_pkg;
    localparam int OPERAND_BITS = 31;
    localparam int PROD_BITS = 2 * OPERAND_BITS;
    localparam int NUM_BITS = 63;
    localparam int DEN_BITS = 61;
    localparam int MAG_BITS = PROD_BITS + 1;
    localparam int CNT_BITS = $clog2(MAG_BITS + 1);

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_CMP = 3'd4;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_ZERO_DEN = 2'd1;
    localparam logic [1:0] ST_DIV_ZERO = 2'd2;

    localparam logic [1:0] CMP_EQ = 2'd0;
    localparam logic [1:0] CMP_GT = 2'd1;
    localparam logic [1:0] CMP_LT = 2'd3;

    typedef logic signed [OPERAND_BITS-1:0] opnd_t;
    typedef logic signed [PROD_BITS:0] wide_t;
    typedef logic [MAG_BITS-1:0] mag_t;

    typedef struct packed {
        logic load;
        logic mul_a;
        logic mul_b;
        logic combine;
        logic gcd_start;
        logic gcd_step;
        logic div_start;
        logic div_step;
        logic div_sel_den;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic gcd_done;
        logic div_done;
        logic quick;
    } sts_t;
endpackage
`default_nettype wire

### rtl/rau_ctrl.sv
// sequencer for the rational arithmetic unit
`default_nettype none
module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_fire,
    input  wire logic out_free,
    input  wire sts_t sts,
    output cmd_t      cmd,
    output logic      busy,
    output logic      done
);
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MA   = 4'd1;
    localparam logic [3:0] S_MB   = 4'd2;
    localparam logic [3:0] S_CMB  = 4'd3;
    localparam logic [3:0] S_GCD  = 4'd4;
    localparam logic [3:0] S_DNS  = 4'd5;
    localparam logic [3:0] S_DN   = 4'd6;
    localparam logic [3:0] S_DDS  = 4'd7;
    localparam logic [3:0] S_DD   = 4'd8;
    localparam logic [3:0] S_FIN  = 4'd9;
    localparam logic [3:0] S_GS   = 4'd10;

    logic [3:0] state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    cmd.load = 1'b1;
                    state_next = S_MA;
                end
            end
            S_MA:
            begin
                cmd.mul_a = 1'b1;
                state_next = S_MB;
            end
            S_MB:
            begin
                cmd.mul_b = 1'b1;
                state_next = S_CMB;
            end
            S_CMB:
            begin
                cmd.combine = 1'b1;
                state_next = sts.quick ? S_FIN : S_GS;
            end
            S_GS:
            begin
                cmd.gcd_start = 1'b1;
                state_next = S_GCD;
            end
            S_GCD:
            begin
                if (sts.gcd_done)
                    state_next = S_DNS;
                else
                    cmd.gcd_step = 1'b1;
            end
            S_DNS:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DN;
            end
            S_DN:
            begin
                if (sts.div_done)
                    state_next = S_DDS;
                else
                    cmd.div_step = 1'b1;
            end
            S_DDS:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel_den = 1'b1;
                state_next = S_DD;
            end
            S_DD:
            begin
                cmd.div_sel_den = 1'b1;
                if (sts.div_done)
                    state_next = S_FIN;
                else
                    cmd.div_step = 1'b1;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = cmd.finish;

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> state_reg == S_IDLE)
        else $error("load outside idle");
    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> out_free)
        else $error("finish while output full");
    a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> busy)
        else $error("not busy after load");
endmodule
`default_nettype wire

### rtl/rau_datapath.sv
// operand products, gcd and exact division datapath
`default_nettype none
module rau_datapath
    import rau_pkg::*;
(
    input  wire logic            clk,
    input  wire cmd_t            cmd,
    input  wire logic [2:0]      op,
    input  wire opnd_t           a_num,
    input  wire opnd_t           a_den,
    input  wire opnd_t           b_num,
    input  wire opnd_t           b_den,
    input  wire logic            reduce_only,
    output sts_t                 sts,
    output logic [NUM_BITS-1:0]  res_num,
    output logic [DEN_BITS-1:0]  res_den,
    output logic [1:0]           cmp_result,
    output logic [1:0]           status
);
    opnd_t an_reg, ad_reg, bn_reg, bd_reg;
    logic [2:0] op_reg;
    logic solo_reg;
    wide_t p1_reg, p2_reg, p3_reg, p4_reg;
    wide_t n_reg, d_reg;
    wide_t n_next, d_next;
    wide_t cmp_diff;
    mag_t y_reg, g_reg;
    mag_t un_reg, ud_reg;
    mag_t n_mag, d_mag;
    logic neg_reg;
    logic [1:0] st_reg, cmp_reg;
    logic [1:0] st_next, cmp_next;
    mag_t rem_reg, quo_reg, dvd_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic gcd_active_reg;
    logic zero_den;
    logic [MAG_BITS:0] shifted;
    logic [MAG_BITS:0] diff;
    logic fin_zero;

    assign zero_den = (ad_reg == '0) || (!solo_reg && bd_reg == '0);

    assign shifted = {rem_reg, dvd_reg[MAG_BITS-1]};
    assign diff = shifted - {1'b0, (gcd_active_reg ? y_reg : g_reg)};

    assign cmp_diff = p3_reg[PROD_BITS] ? (p2_reg - p1_reg) : (p1_reg - p2_reg);
    assign n_mag = mag_t'(n_reg[PROD_BITS] ? -n_reg : n_reg);
    assign d_mag = mag_t'(d_reg[PROD_BITS] ? -d_reg : d_reg);

    always_comb
    begin
        st_next = ST_OK;
        cmp_next = CMP_EQ;
        n_next = '0;
        d_next = wide_t'(1);
        if (zero_den)
            st_next = ST_ZERO_DEN;
        else if (solo_reg)
        begin
            n_next = wide_t'(an_reg);
            d_next = wide_t'(ad_reg);
        end
        else
        begin
            case (op_reg)
                OP_ADD:
                begin
                    n_next = p1_reg + p2_reg; d_next = p3_reg;
                end
                OP_SUB:
                begin
                    n_next = p1_reg - p2_reg; d_next = p3_reg;
                end
                OP_MUL:
                begin
                    n_next = p4_reg; d_next = p3_reg;
                end
                OP_DIV:
                begin
                    if (bn_reg == '0)
                        st_next = ST_DIV_ZERO;
                    n_next = p1_reg; d_next = p2_reg;
                end
                default:
                begin
                    if (cmp_diff != '0)
                        cmp_next = cmp_diff[PROD_BITS] ? CMP_LT : CMP_GT;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            an_reg <= a_num; ad_reg <= a_den; bn_reg <= b_num; bd_reg <= b_den;
            op_reg <= op;
            solo_reg <= reduce_only || (op > OP_CMP);
            gcd_active_reg <= 1'b0;
        end
        if (cmd.mul_a)
        begin
            p1_reg <= wide_t'(an_reg) * wide_t'(bd_reg);
            p2_reg <= wide_t'(bn_reg) * wide_t'(ad_reg);
        end
        if (cmd.mul_b)
        begin
            p3_reg <= wide_t'(ad_reg) * wide_t'(bd_reg);
            p4_reg <= wide_t'(an_reg) * wide_t'(bn_reg);
        end
        if (cmd.combine)
        begin
            st_reg <= st_next;
            cmp_reg <= cmp_next;
            n_reg <= n_next;
            d_reg <= d_next;
        end
        if (cmd.gcd_start)
        begin
            neg_reg <= n_reg[PROD_BITS] ^ d_reg[PROD_BITS];
            un_reg <= n_mag;
            ud_reg <= d_mag;
            y_reg <= d_mag;
            gcd_active_reg <= 1'b1;
            rem_reg <= '0;
            dvd_reg <= n_mag;
            cnt_reg <= CNT_BITS'(MAG_BITS);
        end
        if (cmd.gcd_step)
        begin
            if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                dvd_reg <= {dvd_reg[MAG_BITS-2:0], 1'b0};
                if (!diff[MAG_BITS])
                    rem_reg <= diff[MAG_BITS-1:0];
                else
                    rem_reg <= shifted[MAG_BITS-1:0];
            end
            else
            begin
                y_reg <= rem_reg;
                dvd_reg <= y_reg;
                rem_reg <= '0;
                cnt_reg <= CNT_BITS'(MAG_BITS);
                if (rem_reg == '0)
                begin
                    g_reg <= y_reg;
                    gcd_active_reg <= 1'b0;
                end
            end
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            dvd_reg <= cmd.div_sel_den ? ud_reg : un_reg;
            quo_reg <= '0;
            cnt_reg <= CNT_BITS'(MAG_BITS);
        end
        if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            dvd_reg <= {dvd_reg[MAG_BITS-2:0], 1'b0};
            quo_reg <= {quo_reg[MAG_BITS-2:0], !diff[MAG_BITS]};
            if (!diff[MAG_BITS])
                rem_reg <= diff[MAG_BITS-1:0];
            else
                rem_reg <= shifted[MAG_BITS-1:0];
            if (cnt_reg == CNT_BITS'(1))
            begin
                if (cmd.div_sel_den)
                    ud_reg <= {quo_reg[MAG_BITS-2:0], !diff[MAG_BITS]};
                else
                    un_reg <= {quo_reg[MAG_BITS-2:0], !diff[MAG_BITS]};
            end
        end
    end

    always_comb
    begin
        sts.gcd_done = !gcd_active_reg;
        sts.div_done = (cnt_reg == '0);
        sts.quick = zero_den || (!solo_reg &&
                    (op_reg == OP_CMP || (op_reg == OP_DIV && bn_reg == '0)));
    end

    assign fin_zero = (st_reg != ST_OK) || (!solo_reg && op_reg == OP_CMP);

    always_comb
    begin
        if (fin_zero)
        begin
            res_num = '0;
            res_den = '0;
        end
        else
        begin
            res_num = (neg_reg && un_reg != '0) ? NUM_BITS'(-un_reg) : NUM_BITS'(un_reg);
            res_den = ud_reg[DEN_BITS-1:0];
        end
        cmp_result = (st_reg == ST_OK && !solo_reg && op_reg == OP_CMP) ? cmp_reg : CMP_EQ;
        status = st_reg;
    end
endmodule
`default_nettype wire

### rtl/rational_arith_unit.sv
// top level of the rational arithmetic unit
// usage:
//   s_axis carries one item: op, two fractions and reduce_only in tdata.
//   m_axis returns one item per input: res_num, res_den, cmp_result, status.
//   an item is accepted when s_axis_tvalid and s_axis_tready are high.
//   one item is worked on at a time; s_axis_tready is high only while idle.
//   compare and error cases go straight from the products to the result;
//   otherwise a euclid gcd runs one or more remainder steps, each a
//   shift-subtract remainder plus a swap step, and then the two exact
//   divisions by the gcd run on the serial divider.
//   the next item is accepted the cycle after a result is handed over.
//   the result sits in an output register until m_axis_tready takes it;
//   while the register is full a finished result waits in the datapath
//   and no new item is accepted.
//   reset clears the sequencer and the output valid flag.
`default_nettype none
module rational_arith_unit
    import rau_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // op, a_num, a_den, b_num, b_den, reduce_only
    input  wire logic [127:0] s_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // res_num, res_den, cmp_result, status
    output logic [127:0]      m_axis_tdata
);
    cmd_t cmd;
    sts_t sts;
    logic busy, done, in_fire, out_free;
    logic [NUM_BITS-1:0] rn;
    logic [DEN_BITS-1:0] rd;
    logic [1:0] cr, st;
    logic out_valid_reg;
    logic [127:0] out_data_reg;

    assign s_axis_tready = !busy;
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !out_valid_reg || m_axis_tready;

    rau_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(out_free),
        .sts(sts), .cmd(cmd), .busy(busy), .done(done)
    );

    rau_datapath u_dp (
        .clk(clk), .cmd(cmd),
        .op(s_axis_tdata[2:0]),
        .a_num(s_axis_tdata[33:3]),
        .a_den(s_axis_tdata[64:34]),
        .b_num(s_axis_tdata[95:65]),
        .b_den(s_axis_tdata[126:96]),
        .reduce_only(s_axis_tdata[127]),
        .sts(sts), .res_num(rn), .res_den(rd), .cmp_result(cr), .status(st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (done)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done)
            out_data_reg <= {st, cr, rd, rn};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_data_reg;
endmodule
`default_nettype wire
